// ----- rtl/core/srls_pkg.sv -----
// ----------------------------------------------------------------------------
// srls_pkg
// Types and fixed constants shared by the sample ring log streamer core.
// ----------------------------------------------------------------------------
package srls_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned MvW     = 16;
  localparam int unsigned AdcW    = 12;
  localparam int unsigned RecW    = TimeW + MvW + AdcW;
  localparam int unsigned WordW   = 32;
  localparam int unsigned ReqW    = 3;
  localparam int unsigned PaddrW  = 3;
  localparam int unsigned PdataW  = 32;

  // index at or above this ends a stream: upper 28 bits all ones
  localparam logic [WordW-1:0] NearWrap = 32'hFFFF_FFF0;

  typedef enum logic [ReqW-1:0] {
    ReqPush   = 3'd0,
    ReqClear  = 3'd1,
    ReqStream = 3'd2,
    ReqTick   = 3'd3,
    ReqCancel = 3'd4
  } req_e;

  typedef enum logic [7:0] {
    StIdle     = 8'b0000_0001,
    StOldest   = 8'b0000_0010,
    StReqLo    = 8'b0000_0100,
    StReqHi    = 8'b0000_1000,
    StTickLo   = 8'b0001_0000,
    StTickHi   = 8'b0010_0000,
    StTickData = 8'b0100_0000,
    StTickAdv  = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic [TimeW-1:0] time_s;
    logic [MvW-1:0]   mv;
    logic [AdcW-1:0]  adc;
  } rec_t;

endpackage

// ----- rtl/core/srls_ram.sv -----
// ----------------------------------------------------------------------------
// srls_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module srls_ram #(
  parameter int unsigned Width = 60,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/sample_ring_log_streamer_core.sv -----
// ----------------------------------------------------------------------------
// sample_ring_log_streamer_core
// Ring log of voltage records with absolute indices and stride readout.
// ----------------------------------------------------------------------------
// A command word is taken when start_i is high and busy_o is low. Push, clear,
// cancel and unused codes complete in the accept cycle and busy_o stays low.
// A stream request holds busy_o through states StOldest, StReqLo and StReqHi.
// A tick holds busy_o through StOldest and then, for each record, StTickLo,
// StTickHi, StTickData and StTickAdv (a record that ends the stream stops after
// StTickData, an index found invalid after StTickHi), at most RECORDS_PER_TICK
// records; a tick while no stream is active completes in the accept cycle. The
// steps follow from the shared 32-bit add/compare unit (lower bound, upper
// bound, count, index advance) and the single memory port with registered read.
// Each record word is shown on the rec_* ports for one cycle with
// rec_valid_o high; the receiver cannot stall, and a record appears once the
// walk knows whether it closes the tick: from StTickData if it ends the stream,
// else from StTickAdv or the next StTickHi. Register logging_enable sits at
// byte address 0 of the APB port; pready is always high. Reset empties the log,
// stops streaming and sets logging_enable; the record memory itself is not
// cleared, and the block is idle and ready as soon as reset is released.
// ----------------------------------------------------------------------------
module sample_ring_log_streamer_core
  import srls_pkg::*;
#(
  parameter int unsigned RING_DEPTH       = 4096,
  parameter int unsigned RECORDS_PER_TICK = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,

  input  logic              start_i,
  output logic              busy_o,
  input  logic [ReqW-1:0]   req_type_i,
  input  logic [TimeW-1:0]  sample_time_i,
  input  logic [MvW-1:0]    sample_millivolt_i,
  input  logic [AdcW-1:0]   sample_adc_i,
  input  logic [WordW-1:0]  stream_start_i,
  input  logic [WordW-1:0]  stream_stride_i,
  input  logic [WordW-1:0]  stream_count_i,

  output logic              rec_valid_o,
  output logic [WordW-1:0]  rec_index_o,
  output logic [TimeW-1:0]  rec_time_o,
  output logic [MvW-1:0]    rec_millivolt_o,
  output logic [AdcW-1:0]   rec_adc_o,
  output logic              last_of_run_o,
  output logic              stream_ended_o,

  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned PosW  = $clog2(RING_DEPTH);
  localparam int unsigned HeldW = $clog2(RING_DEPTH + 1);
  localparam int unsigned SumW  = HeldW + 1;
  localparam int unsigned CntW  = $clog2(RECORDS_PER_TICK + 1);

  state_e            state_q, state_d;
  logic              log_en_q;
  logic              streaming_q, streaming_d;
  logic [WordW-1:0]  next_index_q, next_index_d;
  logic [WordW-1:0]  stride_q, stride_d;
  logic [WordW-1:0]  remaining_q, remaining_d;
  logic [PosW-1:0]   wp_q, wp_d;
  logic [HeldW-1:0]  held_q, held_d;
  logic [WordW-1:0]  total_q, total_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              req_tick_q, req_tick_d;
  logic              out_valid_q, out_valid_d;

  logic [WordW-1:0]  oldest_q, oldest_d;
  logic [PosW-1:0]   base_q, base_d;
  logic [PosW-1:0]   off_q, off_d;
  logic              lo_ok_q, lo_ok_d;
  logic [WordW-1:0]  start_q, start_d;
  logic [WordW-1:0]  rq_stride_q, rq_stride_d;
  logic [WordW-1:0]  rq_count_q, rq_count_d;
  logic [WordW-1:0]  pend_index_q, pend_index_d;
  rec_t              pend_rec_q, pend_rec_d;
  logic [WordW-1:0]  out_index_q, out_index_d;
  rec_t              out_rec_q, out_rec_d;
  logic              out_last_q, out_last_d;
  logic              out_ended_q, out_ended_d;

  logic              accept;
  logic              cfg_wr;
  logic [WordW-1:0]  alu_a, alu_b;
  logic              alu_sub;
  logic [WordW:0]    alu_sum;
  logic              alu_carry;
  logic [SumW-1:0]   base_raw;
  logic [PosW:0]     pos_raw;
  logic [PosW-1:0]   rd_pos;
  logic              ram_we;
  logic [PosW-1:0]   ram_addr;
  rec_t              ram_wdata;
  rec_t              ram_rdata;

  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != StIdle);
  assign cfg_wr = psel && penable && pwrite && !paddr[PaddrW-1];
  assign pready = 1'b1;
  assign prdata = paddr[PaddrW-1] ? '0 : PdataW'(log_en_q);

  // shared add/subtract unit
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b1;
    unique case (state_q)
      StOldest: begin
        alu_a = total_q;
        alu_b = WordW'(held_q);
      end
      StReqLo: begin
        alu_a = start_q;
        alu_b = oldest_q;
      end
      StReqHi: begin
        alu_a = start_q;
        alu_b = total_q;
      end
      StTickLo: begin
        alu_a = next_index_q;
        alu_b = oldest_q;
      end
      StTickHi: begin
        alu_a = next_index_q;
        alu_b = total_q;
      end
      StTickData: begin
        alu_a = remaining_q;
        alu_b = WordW'(1);
      end
      StTickAdv: begin
        alu_a   = next_index_q;
        alu_b   = stride_q;
        alu_sub = 1'b0;
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  assign alu_sum   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (WordW+1)'(alu_sub);
  assign alu_carry = alu_sum[WordW];

  // ring position of the oldest entry and of the current offset
  assign base_raw = SumW'(wp_q) + SumW'(RING_DEPTH) - SumW'(held_q);
  assign base_d   = (base_raw >= SumW'(RING_DEPTH)) ? PosW'(base_raw - SumW'(RING_DEPTH))
                                                    : PosW'(base_raw);
  assign pos_raw  = {1'b0, base_q} + {1'b0, off_q};
  assign rd_pos   = (pos_raw >= (PosW+1)'(RING_DEPTH)) ? PosW'(pos_raw - (PosW+1)'(RING_DEPTH))
                                                       : PosW'(pos_raw);

  assign ram_wdata = '{time_s: sample_time_i, mv: sample_millivolt_i, adc: sample_adc_i};

  always_comb begin
    state_d      = state_q;
    streaming_d  = streaming_q;
    next_index_d = next_index_q;
    stride_d     = stride_q;
    remaining_d  = remaining_q;
    wp_d         = wp_q;
    held_d       = held_q;
    total_d      = total_q;
    cnt_d        = cnt_q;
    req_tick_d   = req_tick_q;
    oldest_d     = oldest_q;
    off_d        = off_q;
    lo_ok_d      = lo_ok_q;
    start_d      = start_q;
    rq_stride_d  = rq_stride_q;
    rq_count_d   = rq_count_q;
    pend_index_d = pend_index_q;
    pend_rec_d   = pend_rec_q;
    out_valid_d  = 1'b0;
    out_index_d  = out_index_q;
    out_rec_d    = out_rec_q;
    out_last_d   = out_last_q;
    out_ended_d  = out_ended_q;
    ram_we       = 1'b0;
    ram_addr     = wp_q;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          unique case (req_e'(req_type_i))
            ReqPush: begin
              if (log_en_q) begin
                ram_we  = 1'b1;
                wp_d    = (wp_q == PosW'(RING_DEPTH - 1)) ? '0 : wp_q + PosW'(1);
                held_d  = (held_q < HeldW'(RING_DEPTH)) ? held_q + HeldW'(1) : held_q;
                total_d = total_q + WordW'(1);
              end
            end
            ReqClear: begin
              wp_d    = '0;
              held_d  = '0;
              total_d = '0;
            end
            ReqStream: begin
              start_d     = stream_start_i;
              rq_stride_d = (stream_stride_i == '0) ? WordW'(1) : stream_stride_i;
              rq_count_d  = stream_count_i;
              req_tick_d  = 1'b0;
              state_d     = StOldest;
            end
            ReqTick: begin
              if (streaming_q) begin
                req_tick_d = 1'b1;
                cnt_d      = '0;
                state_d    = StOldest;
              end
            end
            ReqCancel: begin
              streaming_d = 1'b0;
            end
            default: begin
              streaming_d = streaming_q;
            end
          endcase
        end
      end
      StOldest: begin
        oldest_d = alu_carry ? alu_sum[WordW-1:0] : '0;
        state_d  = req_tick_q ? StTickLo : StReqLo;
      end
      StReqLo: begin
        if (!alu_carry) begin
          start_d = oldest_q;
        end
        state_d = StReqHi;
      end
      StReqHi: begin
        if (alu_carry) begin
          streaming_d = 1'b0;
        end else begin
          next_index_d = start_q;
          stride_d     = rq_stride_q;
          remaining_d  = rq_count_q;
          streaming_d  = (rq_count_q != '0);
        end
        state_d = StIdle;
      end
      StTickLo: begin
        lo_ok_d = alu_carry;
        off_d   = alu_sum[PosW-1:0];
        state_d = StTickHi;
      end
      StTickHi: begin
        if (lo_ok_q && !alu_carry) begin
          ram_addr = rd_pos;
          if (cnt_q != '0) begin
            out_valid_d = 1'b1;
            out_index_d = pend_index_q;
            out_rec_d   = pend_rec_q;
            out_last_d  = 1'b0;
            out_ended_d = 1'b0;
          end
          state_d = StTickData;
        end else begin
          streaming_d = 1'b0;
          if (cnt_q != '0) begin
            out_valid_d = 1'b1;
            out_index_d = pend_index_q;
            out_rec_d   = pend_rec_q;
            out_last_d  = 1'b1;
            out_ended_d = 1'b1;
          end
          state_d = StIdle;
        end
      end
      StTickData: begin
        pend_index_d = next_index_q;
        pend_rec_d   = ram_rdata;
        cnt_d        = cnt_q + CntW'(1);
        if (remaining_q != '0) begin
          remaining_d = alu_sum[WordW-1:0];
        end
        if ((remaining_q[WordW-1:1] == '0) || (next_index_q >= NearWrap)) begin
          streaming_d = 1'b0;
          out_valid_d = 1'b1;
          out_index_d = next_index_q;
          out_rec_d   = ram_rdata;
          out_last_d  = 1'b1;
          out_ended_d = 1'b1;
          state_d     = StIdle;
        end else begin
          state_d = StTickAdv;
        end
      end
      StTickAdv: begin
        next_index_d = alu_sum[WordW-1:0];
        if (cnt_q == CntW'(RECORDS_PER_TICK)) begin
          out_valid_d = 1'b1;
          out_index_d = pend_index_q;
          out_rec_d   = pend_rec_q;
          out_last_d  = 1'b1;
          out_ended_d = 1'b0;
          state_d     = StIdle;
        end else begin
          state_d = StTickLo;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      log_en_q     <= 1'b1;
      streaming_q  <= 1'b0;
      next_index_q <= '0;
      stride_q     <= WordW'(1);
      remaining_q  <= '0;
      wp_q         <= '0;
      held_q       <= '0;
      total_q      <= '0;
      cnt_q        <= '0;
      req_tick_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      if (cfg_wr) begin
        log_en_q <= pwdata[0];
      end
      streaming_q  <= streaming_d;
      next_index_q <= next_index_d;
      stride_q     <= stride_d;
      remaining_q  <= remaining_d;
      wp_q         <= wp_d;
      held_q       <= held_d;
      total_q      <= total_d;
      cnt_q        <= cnt_d;
      req_tick_q   <= req_tick_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    oldest_q     <= oldest_d;
    base_q       <= base_d;
    off_q        <= off_d;
    lo_ok_q      <= lo_ok_d;
    start_q      <= start_d;
    rq_stride_q  <= rq_stride_d;
    rq_count_q   <= rq_count_d;
    pend_index_q <= pend_index_d;
    pend_rec_q   <= pend_rec_d;
    out_index_q  <= out_index_d;
    out_rec_q    <= out_rec_d;
    out_last_q   <= out_last_d;
    out_ended_q  <= out_ended_d;
  end

  srls_ram #(
    .Width (RecW),
    .Depth (RING_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign rec_valid_o     = out_valid_q;
  assign rec_index_o     = out_index_q;
  assign rec_time_o      = out_rec_q.time_s;
  assign rec_millivolt_o = out_rec_q.mv;
  assign rec_adc_o       = out_rec_q.adc;
  assign last_of_run_o   = out_last_q;
  assign stream_ended_o  = out_ended_q;

  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= HeldW'(RING_DEPTH))
    else $error("held count above ring depth");

  a_wp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q <= PosW'(RING_DEPTH - 1))
    else $error("write position outside ring");

  a_emit_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ($past(state_q) == StTickHi || $past(state_q) == StTickData ||
                     $past(state_q) == StTickAdv))
    else $error("record word outside a tick walk");

  a_ended_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ended_q) |-> (!streaming_q && out_last_q))
    else $error("stream end flagged while still streaming");

  a_tick_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(RECORDS_PER_TICK))
    else $error("tick emitted too many records");

endmodule

// ----- tb/sv/tb_sample_ring_log_streamer_core.sv -----
// ----------------------------------------------------------------------------
// tb_sample_ring_log_streamer_core
// Self-checking bench for the sample ring log streamer core.
// ----------------------------------------------------------------------------
// Command words are queued by the sequence below and issued by a clocked
// driver on the start/busy handshake. On every accepted word the driver runs a
// software copy of the record ring and stream walk, which queues the records
// that word must produce. A clocked monitor takes each record strobe and
// compares it field by field with the oldest queued record. The run covers
// directed corner words, random stream sessions with logging on and off, and
// a stretch with the sender never idling.
// ----------------------------------------------------------------------------
module tb_sample_ring_log_streamer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import srls_pkg::*;

  localparam int unsigned RingDepth    = 4096;
  localparam int unsigned TickMax      = 8;
  localparam int unsigned ReqCodeMax   = (1 << ReqW) - 1;
  localparam int unsigned RegLogEnable = 0;
  localparam logic [PaddrW-1:0] LogEnAddr = PaddrW'(4 * RegLogEnable);
  localparam int unsigned SettleCycles = 48;

  typedef struct {
    logic [ReqW-1:0]  req;
    logic [TimeW-1:0] time_s;
    logic [MvW-1:0]   mv;
    logic [AdcW-1:0]  adc;
    logic [WordW-1:0] start_idx;
    logic [WordW-1:0] stride;
    logic [WordW-1:0] count;
    bit               wait_drain;
  } cmd_t;

  typedef struct {
    logic [WordW-1:0] index;
    logic [TimeW-1:0] time_s;
    logic [MvW-1:0]   mv;
    logic [AdcW-1:0]  adc;
    logic             last;
    logic             ended;
  } rec_exp_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic              busy_o;
  logic [ReqW-1:0]   req_type_i = '0;
  logic [TimeW-1:0]  sample_time_i = '0;
  logic [MvW-1:0]    sample_millivolt_i = '0;
  logic [AdcW-1:0]   sample_adc_i = '0;
  logic [WordW-1:0]  stream_start_i = '0;
  logic [WordW-1:0]  stream_stride_i = '0;
  logic [WordW-1:0]  stream_count_i = '0;
  logic              rec_valid_o;
  logic [WordW-1:0]  rec_index_o;
  logic [TimeW-1:0]  rec_time_o;
  logic [MvW-1:0]    rec_millivolt_o;
  logic [AdcW-1:0]   rec_adc_o;
  logic              last_of_run_o;
  logic              stream_ended_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [PdataW-1:0] pwdata = '0;
  logic [PdataW-1:0] prdata;
  logic              pready;

  sample_ring_log_streamer_core #(
    .RING_DEPTH       (RingDepth),
    .RECORDS_PER_TICK (TickMax)
  ) uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .req_type_i         (req_type_i),
    .sample_time_i      (sample_time_i),
    .sample_millivolt_i (sample_millivolt_i),
    .sample_adc_i       (sample_adc_i),
    .stream_start_i     (stream_start_i),
    .stream_stride_i    (stream_stride_i),
    .stream_count_i     (stream_count_i),
    .rec_valid_o        (rec_valid_o),
    .rec_index_o        (rec_index_o),
    .rec_time_o         (rec_time_o),
    .rec_millivolt_o    (rec_millivolt_o),
    .rec_adc_o          (rec_adc_o),
    .last_of_run_o      (last_of_run_o),
    .stream_ended_o     (stream_ended_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  // ring copy and stream walk state
  logic [TimeW-1:0] log_time [RingDepth];
  logic [MvW-1:0]   log_mv   [RingDepth];
  logic [AdcW-1:0]  log_adc  [RingDepth];
  logic             log_en    = 1'b1;
  logic [WordW-1:0] wr_pos    = '0;
  logic [WordW-1:0] held_ct   = '0;
  logic [WordW-1:0] total_ct  = '0;
  logic             streaming = 1'b0;
  logic [WordW-1:0] next_idx  = '0;
  logic [WordW-1:0] stride_ct = 1;
  logic [WordW-1:0] left_ct   = '0;

  cmd_t        cmd_q[$];
  cmd_t        cmd_cur;
  rec_exp_t    pending_recs[$];
  rec_exp_t    due_rec;
  int unsigned idle_pct = 8;
  int unsigned gen_items = 0;
  int unsigned accepted_items = 0;
  int unsigned gen_total = 0;
  int unsigned gen_held = 0;
  int unsigned errors = 0;

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic void predict_records(input cmd_t c);
    logic [WordW-1:0] first;
    logic [WordW-1:0] idx;
    logic [WordW-1:0] pos;
    rec_exp_t         run[$];
    rec_exp_t         r;
    first = (total_ct >= held_ct) ? total_ct - held_ct : '0;
    case (c.req)
      ReqPush: begin
        if (log_en) begin
          log_time[wr_pos] = c.time_s;
          log_mv[wr_pos]   = c.mv;
          log_adc[wr_pos]  = c.adc;
          wr_pos = (wr_pos + 1) % RingDepth;
          if (held_ct < RingDepth) held_ct++;
          total_ct++;
        end
      end
      ReqClear: begin
        wr_pos   = '0;
        held_ct  = '0;
        total_ct = '0;
      end
      ReqStream: begin
        idx = (c.start_idx < first) ? first : c.start_idx;
        if (idx >= total_ct) begin
          streaming = 1'b0;
        end else begin
          next_idx  = idx;
          stride_ct = (c.stride == '0) ? 1 : c.stride;
          left_ct   = c.count;
          streaming = (c.count != '0);
        end
      end
      ReqTick: begin
        while (streaming && run.size() < TickMax) begin
          if (held_ct == '0 || next_idx < first || next_idx >= total_ct) begin
            streaming = 1'b0;
            break;
          end
          pos = (wr_pos + RingDepth - held_ct + (next_idx - first)) % RingDepth;
          r.index  = next_idx;
          r.time_s = log_time[pos];
          r.mv     = log_mv[pos];
          r.adc    = log_adc[pos];
          r.last   = 1'b0;
          r.ended  = 1'b0;
          run.push_back(r);
          if (left_ct != '0) left_ct--;
          if (left_ct == '0) begin
            streaming = 1'b0;
            break;
          end
          if (next_idx >= NearWrap) begin
            streaming = 1'b0;
            break;
          end
          next_idx = next_idx + stride_ct;
        end
        if (run.size() != 0) begin
          run[run.size()-1].last  = 1'b1;
          run[run.size()-1].ended = !streaming;
        end
        foreach (run[i]) pending_recs.push_back(run[i]);
      end
      ReqCancel: streaming = 1'b0;
      default: ;
    endcase
  endfunction

  // driver: hold the word until accepted, then advance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        predict_records(cmd_cur);
        accepted_items++;
      end
      if (!start_i || !busy_o) begin
        if (cmd_q.size() != 0 && !(cmd_q[0].wait_drain && pending_recs.size() != 0)
            && $urandom_range(0, 99) >= idle_pct) begin
          cmd_cur = cmd_q.pop_front();
          start_i            <= 1'b1;
          req_type_i         <= cmd_cur.req;
          sample_time_i      <= cmd_cur.time_s;
          sample_millivolt_i <= cmd_cur.mv;
          sample_adc_i       <= cmd_cur.adc;
          stream_start_i     <= cmd_cur.start_idx;
          stream_stride_i    <= cmd_cur.stride;
          stream_count_i     <= cmd_cur.count;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(input string name, input logic [WordW-1:0] want,
                                      input logic [WordW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && rec_valid_o) begin
      if (pending_recs.size() == 0) begin
        $error("unexpected record word, index %0h", rec_index_o);
        errors++;
      end else begin
        due_rec = pending_recs.pop_front();
        check_field("rec_index", due_rec.index, rec_index_o);
        check_field("rec_time", due_rec.time_s, rec_time_o);
        check_field("rec_millivolt", WordW'(due_rec.mv), WordW'(rec_millivolt_o));
        check_field("rec_adc", WordW'(due_rec.adc), WordW'(rec_adc_o));
        check_field("last_of_run", WordW'(due_rec.last), WordW'(last_of_run_o));
        check_field("stream_ended", WordW'(due_rec.ended), WordW'(stream_ended_o));
      end
    end
  end

  function automatic cmd_t rand_cmd(input logic [ReqW-1:0] req);
    cmd_t c;
    c.req        = req;
    c.time_s     = $urandom();
    c.mv         = MvW'($urandom());
    c.adc        = AdcW'($urandom());
    c.start_idx  = $urandom();
    c.stride     = $urandom();
    c.count      = $urandom();
    c.wait_drain = 1'b0;
    return c;
  endfunction

  function automatic void enqueue(input cmd_t c);
    cmd_q.push_back(c);
    gen_items++;
    if (c.req == ReqPush && log_en) begin
      gen_total++;
      if (gen_held < RingDepth) gen_held++;
    end else if (c.req == ReqClear) begin
      gen_total = 0;
      gen_held  = 0;
    end
  endfunction

  function automatic void simple(input logic [ReqW-1:0] req);
    enqueue(rand_cmd(req));
  endfunction

  function automatic void req_stream(input logic [WordW-1:0] s, input logic [WordW-1:0] st,
                                     input logic [WordW-1:0] n);
    cmd_t c;
    c = rand_cmd(ReqStream);
    c.start_idx = s;
    c.stride    = st;
    c.count     = n;
    enqueue(c);
  endfunction

  // pushes, one request and a few ticks, with disturbances and noise mixed in
  function automatic void gen_session();
    cmd_t        c;
    int unsigned oldest;
    int unsigned n_tick;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 4)) simple(ReqW'($urandom_range(0, ReqCodeMax)));
      return;
    end
    repeat ($urandom_range(0, 10)) simple(ReqPush);
    c = rand_cmd(ReqStream);
    oldest = gen_total - gen_held;
    case ($urandom_range(0, 9))
      0: ;
      1: c.start_idx = (oldest == 0) ? 0 : $urandom_range(0, oldest - 1);
      default: if (gen_total != 0) c.start_idx = $urandom_range(oldest, gen_total - 1);
    endcase
    case ($urandom_range(0, 7))
      0: c.stride = '0;
      1: ;
      2: c.stride = '1;
      default: c.stride = $urandom_range(1, 4);
    endcase
    case ($urandom_range(0, 9))
      0: c.count = '0;
      1: ;
      default: c.count = $urandom_range(1, 24);
    endcase
    enqueue(c);
    n_tick = $urandom_range(1, 4);
    repeat (n_tick) begin
      case ($urandom_range(0, 39))
        0, 1: simple(ReqCancel);
        2: simple(ReqClear);
        3, 4: simple(ReqW'(ReqCodeMax - $urandom_range(0, ReqCodeMax - ReqCancel - 1)));
        5, 6, 7, 8, 9, 10: simple(ReqPush);
        default: ;
      endcase
      c = rand_cmd(ReqTick);
      c.wait_drain = ($urandom_range(0, 29) == 0);
      enqueue(c);
    end
  endfunction

  task automatic write_log_enable(input logic v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LogEnAddr;
    pwdata  <= PdataW'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    log_en = v;
  endtask

  task automatic drain();
    int unsigned waited;
    waited = 0;
    while (accepted_items != gen_items) @(posedge clk_i);
    while (pending_recs.size() != 0 && waited < 4000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SettleCycles) @(posedge clk_i);
    if (pending_recs.size() != 0) begin
      $error("%0d expected records never arrived", pending_recs.size());
      errors++;
      pending_recs.delete();
    end
  endtask

  task automatic run_random(input int unsigned n);
    int unsigned target;
    target = gen_items + n;
    while (gen_items < target) gen_session();
  endtask

  initial begin
    cmd_t c;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_log_enable(1'b1);

    c = rand_cmd(ReqPush);
    c.time_s = '0;
    c.mv     = '0;
    c.adc    = '0;
    enqueue(c);
    c.time_s = '1;
    c.mv     = '1;
    c.adc    = '1;
    enqueue(c);
    repeat (4) simple(ReqPush);
    simple(ReqTick);
    for (int u = ReqCancel + 1; u <= ReqCodeMax; u++) simple(ReqW'(u));
    req_stream(0, 0, 3);
    simple(ReqTick);
    req_stream(32'hFFFF_FFFF, 1, 5);
    simple(ReqTick);
    req_stream(1, 1, 0);
    simple(ReqTick);
    req_stream(0, 1, 32'hFFFF_FFFF);
    simple(ReqTick);
    req_stream(5, 32'hFFFF_FFFF, 20);
    simple(ReqTick);
    req_stream(2, 2, 9);
    simple(ReqCancel);
    simple(ReqTick);
    req_stream(0, 1, 4);
    simple(ReqClear);
    simple(ReqTick);
    repeat (12) simple(ReqPush);
    req_stream(0, 1, 10);
    simple(ReqTick);
    simple(ReqTick);
    drain();

    run_random(200);
    drain();

    write_log_enable(1'b0);
    run_random(50);
    drain();

    // clear, then run with no idling
    write_log_enable(1'b1);
    idle_pct = 0;
    simple(ReqClear);
    run_random(80);
    drain();
    idle_pct = 8;
    run_random(100);
    drain();

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/srls_pkg.sv
rtl/core/srls_ram.sv
rtl/core/sample_ring_log_streamer_core.sv
tb/sv/tb_sample_ring_log_streamer_core.sv
